/* rtl/sam_pkg.sv */
package sam_pkg;

  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_MERGE  = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

endpackage

/* rtl/sam_if.sv */
interface sam_in_if import sam_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [FUNC_W-1:0]   func;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface sam_out_if import sam_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [POS_W-1:0]    position;
  logic signed [VALUE_W-1:0]  value_out;
  logic                       last;

  modport source (output valid, position, value_out, last, input ready);
  modport sink   (input valid, position, value_out, last, output ready);
endinterface

/* rtl/sorted_array_merge.sv */
// load requests (append to list a or b) are accepted one per cycle while no merge is running
// a merge request emits count_a+count_b results,
// one per cycle, set by the single read port of each list memory
// results stall in place while the result channel is not ready
// synchronous active-low reset clears both counts, the state machine and the
// result valid; list memory contents are not reset and are used only below the counts
module sorted_array_merge import sam_pkg::*; #(
  parameter int LIST_DEPTH  = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sam_in_if.sink    in_ch,
  sam_out_if.source out_ch
);

  // count holds 0..LIST_DEPTH, position counter holds up to 2*LIST_DEPTH-1
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int PCT_W = CNT_W + 1;
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // list storage, one write and one registered read per cycle each
  logic [VALUE_WIDTH-1:0] mem_a [LIST_DEPTH];
  logic [VALUE_WIDTH-1:0] mem_b [LIST_DEPTH];

  logic [VALUE_WIDTH-1:0] rd_a_r, rd_b_r;   // tail elements of each list

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_a_r, count_a_nxt;
  logic [CNT_W-1:0] count_b_r, count_b_nxt;
  logic [PCT_W-1:0] pos_r, pos_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]       out_pos_r, out_pos_nxt;
  logic [VALUE_WIDTH-1:0] out_val_r, out_val_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   req_fire;
  logic                   step;
  logic                   take_a;
  logic                   wr_a, wr_b;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [CNT_W-1:0]       rd_a_cnt, rd_b_cnt;
  logic [IDX_W-1:0]       rd_a_idx, rd_b_idx;
  logic [PCT_W-1:0]       total;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign req_fire    = in_ch.valid && in_ch.ready;

  // input value is taken as raw 32 bits, then fitted to the storage width
  assign wr_data = VALUE_WIDTH'($unsigned(in_ch.value));
  assign total   = PCT_W'(count_a_r) + PCT_W'(count_b_r);

  // a merge step advances whenever the result register is free or draining
  assign step = (state_r == ST_MERGE) && (!out_valid_r || out_ch.ready);

  // larger tail wins, ties go to list b so b lands at the higher position
  assign take_a = (count_a_r != '0) &&
                  ((count_b_r == '0) || ($signed(rd_a_r) > $signed(rd_b_r)));

  always_comb begin
    state_nxt     = state_r;
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    pos_nxt       = pos_r;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (req_fire) begin
          case (in_ch.func)
            FUNC_LOAD_A: begin
              // appends past the depth are dropped
              if (count_a_r < CNT_W'(LIST_DEPTH)) begin
                wr_a        = 1'b1;
                count_a_nxt = count_a_r + 1'b1;
              end
            end
            FUNC_LOAD_B: begin
              if (count_b_r < CNT_W'(LIST_DEPTH)) begin
                wr_b        = 1'b1;
                count_b_nxt = count_b_r + 1'b1;
              end
            end
            FUNC_MERGE: begin
              // merge of two empty lists emits nothing
              if (total != '0) begin
                pos_nxt   = total - 1'b1;
                state_nxt = ST_MERGE;
              end
            end
            default: ;  // unused code is accepted and ignored
          endcase
        end
      end
      ST_MERGE: begin
        if (step) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = POS_W'(pos_r);
          out_last_nxt  = (pos_r == '0);
          if (take_a) begin
            out_val_nxt = rd_a_r;
            count_a_nxt = count_a_r - 1'b1;
          end else begin
            out_val_nxt = rd_b_r;
            count_b_nxt = count_b_r - 1'b1;
          end
          if (pos_r == '0) begin
            // both counts reach zero with this step
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // prefetch the tail of each list as it will stand next cycle
  assign rd_a_cnt = count_a_nxt - 1'b1;
  assign rd_b_cnt = count_b_nxt - 1'b1;
  assign rd_a_idx = rd_a_cnt[IDX_W-1:0];
  assign rd_b_idx = rd_b_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[count_a_r[IDX_W-1:0]] <= wr_data;
    end
    rd_a_r <= mem_a[rd_a_idx];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[count_b_r[IDX_W-1:0]] <= wr_data;
    end
    rd_b_r <= mem_b[rd_b_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    out_pos_r  <= out_pos_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.value_out = VALUE_W'(out_val_r);
  assign out_ch.last      = out_last_r;

endmodule
